// ===== hdl/spike_vote_bandit_reward_core_defines.svh =====
// Assertion macros shared by the spike vote bandit reward block.
`ifndef SPIKE_VOTE_BANDIT_REWARD_CORE_DEFINES_SVH
`define SPIKE_VOTE_BANDIT_REWARD_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SVBR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("svbr: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SVBR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("svbr: next-cycle check failed");

`endif

// ===== hdl/svbr_pkg.sv =====
// Types and constants of the spike vote bandit reward block.
`default_nettype none
package svbr_pkg;

  localparam int PROB_ARMS = 8;
  localparam int ARM_W     = 3;
  localparam int ROLL_W    = 16;
  localparam int PROB_W    = 16;
  localparam int FRAME_W   = 16;
  localparam int ACNT_W    = 4;
  localparam int SCORE_W   = 32;
  localparam int WCNT_W    = 16;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 2;

  localparam logic [FRAME_W-1:0] FRAME_TICKS_RST = 16'd200;
  localparam logic [ACNT_W-1:0]  ARM_COUNT_RST   = 4'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_TICKS = 2'd0,
    CFG_ARM_COUNT   = 2'd1,
    CFG_PROB_LO     = 2'd2,
    CFG_PROB_HI     = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    KIND_SPIKE = 1'b0,
    KIND_TICK  = 1'b1
  } kind_t;

  typedef struct packed {
    logic              kind;
    logic [ARM_W-1:0]  arm;
    logic [ROLL_W-1:0] roll;
    logic [ARM_W-1:0]  fallback_arm;
  } in_item_t;

  typedef struct packed {
    logic [ARM_W-1:0]  choice;
    logic [WCNT_W-1:0] best;
  } vote_t;

endpackage
`default_nettype wire

// ===== hdl/svbr_in_if.sv =====
// Input channel: spike events and timer ticks.
`default_nettype none
interface svbr_in_if;
  import svbr_pkg::*;

  logic              valid;
  logic              ready;
  logic              kind;
  logic [ARM_W-1:0]  arm;
  logic [ROLL_W-1:0] roll;
  logic [ARM_W-1:0]  fallback_arm;

  modport source (output valid, kind, arm, roll, fallback_arm, input ready);
  modport sink   (input valid, kind, arm, roll, fallback_arm, output ready);
endinterface
`default_nettype wire

// ===== hdl/svbr_out_if.sv =====
// Result channel: one reward decision per frame.
`default_nettype none
interface svbr_out_if;
  import svbr_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      rewarded;
  logic [ARM_W-1:0]          chosen_arm;
  logic [WCNT_W-1:0]         winning_count;
  logic signed [SCORE_W-1:0] score;

  modport source (output valid, rewarded, chosen_arm, winning_count, score, input ready);
  modport sink   (input valid, rewarded, chosen_arm, winning_count, score, output ready);
endinterface
`default_nettype wire

// ===== hdl/svbr_argmax.sv =====
// Argmax of eligible votes, low index wins ties; all zero: fallback if eligible, else last.
`default_nettype none
module svbr_argmax #(
  parameter int NUM        = 8,
  parameter int COUNT_BITS = 16
) (
  input  wire logic [COUNT_BITS-1:0]      counts [NUM],
  input  wire logic [svbr_pkg::ACNT_W-1:0] n_active,
  input  wire logic [svbr_pkg::ARM_W-1:0]  fallback_arm,
  output logic [svbr_pkg::ARM_W-1:0]       choice,
  output logic [COUNT_BITS-1:0]            best
);
  import svbr_pkg::*;

  logic [ACNT_W-1:0] fb_ext;

  always_comb begin
    fb_ext = {{(ACNT_W-ARM_W){1'b0}}, fallback_arm};
    if (fb_ext < n_active) begin
      choice = fallback_arm;
    end else begin
      choice = ARM_W'(n_active - ACNT_W'(1));
    end
    best = '0;
    for (int i = 0; i < NUM; i++) begin
      if (ACNT_W'(i) < n_active && counts[i] > best) begin
        best   = counts[i];
        choice = ARM_W'(i);
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/spike_vote_bandit_reward_core.sv =====
// Top level of the spike vote bandit reward block.
//
// in_ch carries spike events (kind 0, vote for arm) and timer ticks (kind 1,
// with roll and fallback_arm). A transaction completes when valid and ready
// are high at a rising clk edge; out_ch works the same way.
// Each accepted transaction lands in an input register; as it leaves it, the
// vote counters and frame counter are updated in one pass, and a tick that
// closes a frame updates the score and loads the result register, which drives
// out_ch.valid. One transaction is taken per cycle while no tick waits in the
// input register. The vote argmax over up to eight arms sets the longest path.
// When out_ch stalls with a result pending, spikes still flow; any tick
// waits in the input register until the result register frees.
// cfg_we writes register cfg_idx (0 frame_ticks, 1 arm_count, 2 prob_arms_lo,
// 3 prob_arms_hi) from cfg_wdata; write only while the block is idle.
// Synchronous active-low reset clears the counters, the score, both valid
// flags and restores frame_ticks 200, arm_count 8 and zero probabilities.
`default_nettype none
module spike_vote_bandit_reward_core #(
  parameter int MAX_ARMS   = 8,
  parameter int COUNT_BITS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  svbr_in_if.sink                               in_ch,
  svbr_out_if.source                            out_ch,
  input  wire logic                             cfg_we,
  input  wire logic [svbr_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [svbr_pkg::CFG_W-1:0]       cfg_wdata
);
  import svbr_pkg::*;
  `include "spike_vote_bandit_reward_core_defines.svh"

  localparam int ELIG = (MAX_ARMS < PROB_ARMS) ? MAX_ARMS : PROB_ARMS;

  logic [FRAME_W-1:0]    frame_ticks_r;
  logic [ACNT_W-1:0]     arm_count_r;
  logic [CFG_W-1:0]      prob_lo_r;
  logic [CFG_W-1:0]      prob_hi_r;

  logic                  s1_valid_r;
  in_item_t              s1_item_r;
  logic                  s1_adv;
  logic                  decide;
  logic                  out_free;

  logic [COUNT_BITS-1:0] counts_r   [MAX_ARMS];
  logic [COUNT_BITS-1:0] counts_nxt [MAX_ARMS];
  logic [COUNT_BITS-1:0] elig_cnt   [ELIG];
  logic                  counts_zero;

  logic [FRAME_W-1:0]    frame_cnt_r;
  logic [FRAME_W-1:0]    frame_inc;
  logic [SCORE_W-1:0]    score_r;
  logic [SCORE_W-1:0]    score_nxt;

  logic [ACNT_W-1:0]     n_active;
  logic [ARM_W-1:0]      choice;
  logic [COUNT_BITS-1:0] best;
  logic [WCNT_W+COUNT_BITS-1:0] best_ext;
  logic [CFG_W-1:0]      prob_word;
  logic [PROB_W-1:0]     prob;
  logic                  reward;

  logic                  out_valid_r;
  logic                  rewarded_r;
  logic [ARM_W-1:0]      chosen_arm_r;
  logic [WCNT_W-1:0]     winning_count_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_ticks_r <= FRAME_TICKS_RST;
      arm_count_r   <= ARM_COUNT_RST;
      prob_lo_r     <= '0;
      prob_hi_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_FRAME_TICKS: frame_ticks_r <= cfg_wdata[FRAME_W-1:0];
        CFG_ARM_COUNT:   arm_count_r   <= cfg_wdata[ACNT_W-1:0];
        CFG_PROB_LO:     prob_lo_r     <= cfg_wdata;
        CFG_PROB_HI:     prob_hi_r     <= cfg_wdata;
        default:         ;
      endcase
    end
  end

  // handshake
  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_adv      = s1_valid_r && (s1_item_r.kind == KIND_SPIKE || out_free);
  assign in_ch.ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_item_r.kind         <= in_ch.kind;
      s1_item_r.arm          <= in_ch.arm;
      s1_item_r.roll         <= in_ch.roll;
      s1_item_r.fallback_arm <= in_ch.fallback_arm;
    end
  end

  // frame and vote state
  assign frame_inc = frame_cnt_r + FRAME_W'(1);
  assign decide    = s1_item_r.kind == KIND_TICK && frame_inc == frame_ticks_r;

  always_comb begin
    counts_zero = 1'b1;
    for (int i = 0; i < MAX_ARMS; i++) begin
      counts_nxt[i] = counts_r[i];
      if (s1_adv && decide) begin
        counts_nxt[i] = '0;
      end else if (s1_adv && s1_item_r.kind == KIND_SPIKE &&
                   int'(s1_item_r.arm) == i && !(&counts_r[i])) begin
        counts_nxt[i] = counts_r[i] + COUNT_BITS'(1);
      end
      if (counts_r[i] != '0) counts_zero = 1'b0;
    end
    for (int i = 0; i < ELIG; i++) begin
      elig_cnt[i] = counts_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_ARMS; i++) counts_r[i] <= '0;
      frame_cnt_r <= '0;
      score_r     <= '0;
    end else begin
      counts_r <= counts_nxt;
      if (s1_adv && s1_item_r.kind == KIND_TICK) begin
        frame_cnt_r <= decide ? '0 : frame_inc;
      end
      if (s1_adv && decide) begin
        score_r <= score_nxt;
      end
    end
  end

  // decision
  always_comb begin
    if (arm_count_r == '0) begin
      n_active = ACNT_W'(1);
    end else if (arm_count_r > ACNT_W'(ELIG)) begin
      n_active = ACNT_W'(ELIG);
    end else begin
      n_active = arm_count_r;
    end
  end

  svbr_argmax #(
    .NUM        (ELIG),
    .COUNT_BITS (COUNT_BITS)
  ) u_argmax (
    .counts       (elig_cnt),
    .n_active     (n_active),
    .fallback_arm (s1_item_r.fallback_arm),
    .choice       (choice),
    .best         (best)
  );

  assign prob_word = choice[ARM_W-1] ? prob_hi_r : prob_lo_r;
  assign prob      = prob_word[choice[1:0]*PROB_W +: PROB_W];
  assign reward    = s1_item_r.roll < prob;
  assign score_nxt = reward ? score_r + SCORE_W'(1) : score_r - SCORE_W'(1);
  assign best_ext  = {{WCNT_W{1'b0}}, best};

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && decide) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && decide) begin
      rewarded_r      <= reward;
      chosen_arm_r    <= choice;
      winning_count_r <= best_ext[WCNT_W-1:0];
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.rewarded      = rewarded_r;
  assign out_ch.chosen_arm    = chosen_arm_r;
  assign out_ch.winning_count = winning_count_r;
  assign out_ch.score         = $signed(score_r);

  // checks
  `SVBR_ASSERT_NXT(a_decide_loads_out, clk, rst_n, s1_adv && decide, out_valid_r)
  `SVBR_ASSERT_NXT(a_decide_clears_frame, clk, rst_n, s1_adv && decide, frame_cnt_r == '0)
  `SVBR_ASSERT_NXT(a_decide_clears_votes, clk, rst_n, s1_adv && decide, counts_zero)
  `SVBR_ASSERT_IMP(a_tick_waits_for_room, clk, rst_n, s1_valid_r && s1_item_r.kind == KIND_TICK && !out_free, !s1_adv)

endmodule
`default_nettype wire
